// ===== rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial division prime tester.
`timescale 1ns / 1ps
package tdpt_pkg;

    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [COUNT_W-1:0] PRIME_COUNT = 11'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_DIV,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic start;
    } t_div_ctl;

endpackage

// ===== rtl/tdpt_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tdpt_div #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdpt_pkg::t_div_ctl    i_ctl,
    input  logic [NUM_WIDTH-1:0]  i_dividend,
    input  logic [NUM_WIDTH-1:0]  i_divisor,
    output tdpt_pkg::t_div_stat   o_stat,
    output logic [NUM_WIDTH-1:0]  o_quotient,
    output logic [NUM_WIDTH-1:0]  o_remainder
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] r_quo;
    logic [NUM_WIDTH-1:0] r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [NUM_WIDTH:0]   rem_sh;
    logic [NUM_WIDTH:0]   rem_dif;
    logic                 qbit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_WIDTH-1]};
        rem_dif = rem_sh - {1'b0, i_divisor};
        qbit    = (rem_sh >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_WIDTH-2:0], qbit};
            r_rem <= qbit ? rem_dif[NUM_WIDTH-1:0] : rem_sh[NUM_WIDTH-1:0];
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

// ===== rtl/tdpt_seq.sv =====
// Candidate sequencer: steps the trial divisor and accumulates the divisor count.
`timescale 1ns / 1ps
module tdpt_seq #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_WIDTH-1:0]          i_number,
    input  logic                          i_hold,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [tdpt_pkg::COUNT_W-1:0]  o_count,
    output logic                          o_prime
);

    tdpt_pkg::t_seq_state r_state;
    tdpt_pkg::t_seq_state n_state;

    logic [NUM_WIDTH-1:0]          r_n;
    logic [NUM_WIDTH-1:0]          r_i;
    logic [tdpt_pkg::COUNT_W-1:0]  r_cnt;
    logic [NUM_WIDTH-1:0]          n_n;
    logic [NUM_WIDTH-1:0]          n_i;
    logic [tdpt_pkg::COUNT_W-1:0]  n_cnt;

    tdpt_pkg::t_div_ctl    div_ctl;
    tdpt_pkg::t_div_stat   div_stat;
    logic [NUM_WIDTH-1:0]  quo;
    logic [NUM_WIDTH-1:0]  rem;
    logic [tdpt_pkg::COUNT_W:0] sum;
    logic                  done;

    tdpt_div #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (r_n),
        .i_divisor   (r_i),
        .o_stat      (div_stat),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_i   <= n_i;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_i           = r_i;
        n_cnt         = r_cnt;
        div_ctl.start = 1'b0;
        done          = 1'b0;
        sum           = {1'b0, r_cnt} + ((quo != r_i) ? 12'd2 : 12'd1);
        unique case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_n   = i_number;
                    n_i   = NUM_WIDTH'(1);
                    n_cnt = '0;
                    n_state = (i_number == '0) ? tdpt_pkg::S_DONE : tdpt_pkg::S_LAUNCH;
                end
            end
            tdpt_pkg::S_LAUNCH: begin
                div_ctl.start = 1'b1;
                n_state       = tdpt_pkg::S_DIV;
            end
            tdpt_pkg::S_DIV: begin
                if (div_stat.done) begin
                    if (quo < r_i) begin
                        n_state = tdpt_pkg::S_DONE;
                    end else begin
                        if (rem == '0) begin
                            n_cnt = sum[tdpt_pkg::COUNT_W] ? tdpt_pkg::COUNT_MAX
                                                           : sum[tdpt_pkg::COUNT_W-1:0];
                        end
                        n_i     = r_i + 1'b1;
                        n_state = tdpt_pkg::S_LAUNCH;
                    end
                end
            end
            tdpt_pkg::S_DONE: begin
                if (!i_hold) begin
                    done    = 1'b1;
                    n_state = tdpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != tdpt_pkg::S_IDLE);
    assign o_done  = done;
    assign o_count = r_cnt;
    assign o_prime = (r_cnt == tdpt_pkg::PRIME_COUNT);

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// Top level of the trial division divisor counter and prime tester.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------
//  request | i_in_valid  | o_in_stall  | i_number_in
//  result  | o_out_valid | i_out_stall | o_divisor_count, o_is_prime
//
// One request at a time: for n >= 1 it takes floor(sqrt(n)) + 1 trial
// divisors, each launched into the radix-2 divider in turn; n = 0 goes
// straight to the final state without a division.
// Reset is synchronous, active low, and clears the sequencer and the
// output valid. A finished result waits in the output register while
// the next request is taken; a stalled result holds the sequencer at
// its final state.
`timescale 1ns / 1ps
module trial_division_prime_test #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [NUM_WIDTH-1:0]          i_number_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tdpt_pkg::COUNT_W-1:0]  o_divisor_count,
    output logic                          o_is_prime
);

    logic                          busy;
    logic                          start;
    logic                          hold;
    logic                          done;
    logic [tdpt_pkg::COUNT_W-1:0]  count;
    logic                          prime;

    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [tdpt_pkg::COUNT_W-1:0]  r_count;
    logic                          r_prime;

    assign start = i_in_valid && !busy;
    assign hold  = r_out_valid && i_out_stall;

    tdpt_seq #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_number (i_number_in),
        .i_hold   (hold),
        .o_busy   (busy),
        .o_done   (done),
        .o_count  (count),
        .o_prime  (prime)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_count <= count;
            r_prime <= prime;
        end
    end

    assign o_in_stall      = busy;
    assign o_out_valid     = r_out_valid;
    assign o_divisor_count = r_count;
    assign o_is_prime      = r_prime;

    a_done_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !hold)
        else $error("result loaded over a stalled result");

    a_prime_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_prime) |-> (o_divisor_count == tdpt_pkg::PRIME_COUNT))
        else $error("prime flag disagrees with divisor count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after accepting a request");

endmodule

// ===== tb/sv/trial_division_prime_test_tb.sv =====
// Self-checking testbench for the trial division divisor counter and prime tester.
`timescale 1ns / 1ps
module trial_division_prime_test_tb;

    localparam int NUM_WIDTH = 32;
    localparam int HOLDOFF_CYCLES = 2500;
    localparam int DRAIN_CYCLES = 20;
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

    typedef struct {
        logic [tdpt_pkg::COUNT_W-1:0] count;
        logic                         prime;
    } t_divisor_result;

    typedef enum int {
        RX_FLOW,
        RX_RANDOM,
        RX_BLOCKED
    } t_rx_kind;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [NUM_WIDTH-1:0]         number;
    logic                         out_valid;
    logic                         out_stall;
    logic                         out_stall_pattern;
    logic                         holding;
    logic [tdpt_pkg::COUNT_W-1:0] divisor_count;
    logic                         is_prime;

    t_divisor_result   pending_results[$];
    int                mismatch_count = 0;
    longint unsigned   cycle_count = 0;
    bit                sender_idles = 1'b0;
    int                burst_left = 0;
    event              holdoff_start;

    assign out_stall = out_stall_pattern | holding;

    trial_division_prime_test #(
        .NUM_WIDTH(NUM_WIDTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_number_in    (number),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_divisor_count(divisor_count),
        .o_is_prime     (is_prime)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_divisor_result count_divisors(input logic [NUM_WIDTH-1:0] n);
        longint unsigned value;
        longint unsigned trial;
        longint unsigned total;
        t_divisor_result res;
        value = n;
        total = 0;
        if (value != 0) begin
            for (trial = 1; trial <= value / trial; trial++) begin
                if (value % trial == 0) begin
                    total++;
                    if (value / trial != trial)
                        total++;
                end
            end
        end
        res.count = (total > tdpt_pkg::COUNT_MAX) ? tdpt_pkg::COUNT_MAX
                                                  : total[tdpt_pkg::COUNT_W-1:0];
        res.prime = (total == tdpt_pkg::PRIME_COUNT);
        return res;
    endfunction

    function automatic logic [NUM_WIDTH-1:0] pick_number();
        int unsigned sel;
        int unsigned root;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            root = $urandom_range(0, 1024);
            return root * root;
        end
        if (sel < 60)
            return $urandom_range(0, 4095);
        if (sel < 88)
            return $urandom_range(0, 65535);
        if (sel < 98)
            return $urandom_range(0, 1 << 20);
        return $urandom_range(0, 1 << 22);
    endfunction

    // receiver stall pattern: free flow, random stalls, solid stalls
    initial begin : receiver
        int       phase_left;
        t_rx_kind phase_kind;
        phase_left = 0;
        phase_kind = RX_FLOW;
        out_stall_pattern = 1'b0;
        forever begin
            @(negedge clk);
            if (phase_left == 0) begin
                phase_kind = t_rx_kind'($urandom_range(0, 2));
                phase_left = $urandom_range(4, 60);
            end
            phase_left--;
            case (phase_kind)
                RX_FLOW: begin
                    out_stall_pattern <= 1'b0;
                end
                RX_RANDOM: begin
                    out_stall_pattern <= $urandom_range(0, 1);
                end
                default: begin
                    out_stall_pattern <= 1'b1;
                end
            endcase
        end
    end

    initial begin : holdoff
        holding = 1'b0;
        forever begin
            @(holdoff_start);
            holding <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clk);
            holding <= 1'b0;
        end
    end

    always @(posedge clk) begin : result_check
        t_divisor_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: divisor_count %0d is_prime %0d",
                       divisor_count, is_prime);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (divisor_count !== want.count) begin
                    $error("divisor_count mismatch: expected %0d, actual %0d",
                           want.count, divisor_count);
                    mismatch_count++;
                end
                if (is_prime !== want.prime) begin
                    $error("is_prime mismatch: expected %0d, actual %0d",
                           want.prime, is_prime);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic pace_sender();
        int gap;
        if (!sender_idles)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    task automatic send_number(input logic [NUM_WIDTH-1:0] n);
        in_valid <= 1'b1;
        number <= n;
        do @(posedge clk); while (in_stall);
        pending_results.insert(pending_results.size(), count_divisors(n));
        @(negedge clk);
        pace_sender();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic test_corner_numbers();
        logic [NUM_WIDTH-1:0] corners[$];
        corners = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd16, 32'd25, 32'd49,
                    32'd97, 32'd100, 32'd255, 32'd256, 32'd1024, 32'd65025, 32'd65521,
                    32'd65536, 32'd65537, 32'd720720, 32'd1000003, 32'hFFFF_FFFF};
        sender_idles = 1'b0;
        foreach (corners[k])
            send_number(corners[k]);
        wait_drained();
    endtask

    task automatic test_random_numbers();
        sender_idles = 1'b1;
        burst_left = 0;
        repeat (60) send_number(pick_number());
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        sender_idles = 1'b0;
        -> holdoff_start;
        repeat (8) send_number($urandom_range(0, 255));
        wait_drained();
    endtask

    task automatic test_drain_pause();
        sender_idles = 1'b1;
        burst_left = 0;
        repeat (4) begin
            repeat (3) send_number($urandom_range(0, 4095));
            wait_drained();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        number = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_corner_numbers();
        test_random_numbers();
        test_output_holdoff();
        test_drain_pause();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdpt_pkg.sv
rtl/tdpt_div.sv
rtl/tdpt_seq.sv
rtl/trial_division_prime_test.sv
tb/sv/trial_division_prime_test_tb.sv
